### src/lsps_pkg.sv
package lsps_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_MODE  = 2'd1;
  localparam logic [1:0] OP_PULSE = 2'd2;

  localparam logic [2:0] MODE_OFF        = 3'd0;
  localparam logic [2:0] MODE_CONNECTED  = 3'd1;
  localparam logic [2:0] MODE_CONNECTING = 3'd2;
  localparam logic [2:0] MODE_BOOT       = 3'd3;
  localparam logic [2:0] MODE_ERROR      = 3'd4;

  localparam int MS_W = 10;
  localparam logic [MS_W-1:0] PULSE_MS = 10'd60;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] mode_value;
  } in_item_t;

  typedef struct packed {
    logic       pin_level;
    logic [2:0] shown_mode;
  } out_item_t;

  // Codes above error all play the error pattern.
  function automatic logic [2:0] pattern_row(input logic [2:0] mode);
    pattern_row = (mode > MODE_ERROR) ? MODE_ERROR : mode;
  endfunction

  function automatic logic [2:0] seg_count(input logic [2:0] mode);
    case (pattern_row(mode))
      MODE_OFF:        seg_count = 3'd1;
      MODE_CONNECTED:  seg_count = 3'd1;
      MODE_CONNECTING: seg_count = 3'd2;
      MODE_BOOT:       seg_count = 3'd2;
      default:         seg_count = 3'd4;
    endcase
  endfunction

  function automatic logic [MS_W-1:0] seg_ms(input logic [2:0] mode, input logic [1:0] idx);
    seg_ms = '0;
    case (pattern_row(mode))
      MODE_OFF:        seg_ms = (idx == 2'd0) ? 10'd1000 : 10'd0;
      MODE_CONNECTED:  seg_ms = (idx == 2'd0) ? 10'd1000 : 10'd0;
      MODE_CONNECTING: seg_ms = (idx <= 2'd1) ? 10'd200 : 10'd0;
      MODE_BOOT:       seg_ms = (idx <= 2'd1) ? 10'd500 : 10'd0;
      default:         seg_ms = (idx == 2'd3) ? 10'd700 : 10'd150;
    endcase
  endfunction

  function automatic logic seg_lit(input logic [2:0] mode, input logic [1:0] idx);
    seg_lit = 1'b0;
    case (pattern_row(mode))
      MODE_OFF:        seg_lit = 1'b0;
      MODE_CONNECTED:  seg_lit = (idx == 2'd0);
      MODE_CONNECTING: seg_lit = (idx == 2'd0);
      MODE_BOOT:       seg_lit = (idx == 2'd0);
      default:         seg_lit = (idx == 2'd0) || (idx == 2'd2);
    endcase
  endfunction

endpackage

### src/lsps_seq.sv
module lsps_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  lsps_pkg::in_item_t   item,
  input  logic                 active_low,
  output lsps_pkg::out_item_t  result
);

  logic [2:0]                requested_r, requested_nxt;
  logic [2:0]                latched_r, latched_nxt;
  logic                      pend_r, pend_nxt;
  logic                      in_pulse_r, in_pulse_nxt;
  logic [1:0]                seg_r, seg_nxt;
  logic [lsps_pkg::MS_W-1:0] rem_r, rem_nxt;
  logic                      led_r, led_nxt;
  logic                      end_seg;
  logic [2:0]                seg_next_cnt;

  always_comb begin
    requested_nxt = requested_r;
    latched_nxt   = latched_r;
    pend_nxt      = pend_r;
    in_pulse_nxt  = in_pulse_r;
    seg_nxt       = seg_r;
    rem_nxt       = rem_r;
    led_nxt       = led_r;
    end_seg       = 1'b0;
    seg_next_cnt  = {1'b0, seg_r} + 3'd1;

    case (item.op)
      lsps_pkg::OP_TICK: begin
        if (rem_r > lsps_pkg::MS_W'(1)) begin
          rem_nxt = rem_r - lsps_pkg::MS_W'(1);
        end else begin
          end_seg = 1'b1;
        end
      end
      lsps_pkg::OP_MODE: begin
        requested_nxt = item.mode_value;
        end_seg       = 1'b1;
      end
      lsps_pkg::OP_PULSE: begin
        pend_nxt = 1'b1;
        end_seg  = 1'b1;
      end
      default: ;
    endcase

    if (end_seg) begin
      if (in_pulse_r) begin
        if (seg_r == 2'd0) begin
          seg_nxt = 2'd1;
          rem_nxt = lsps_pkg::PULSE_MS;
          led_nxt = 1'b0;
        end else begin
          in_pulse_nxt = 1'b0;
          seg_nxt      = 2'd0;
          latched_nxt  = requested_nxt;
          rem_nxt      = lsps_pkg::seg_ms(requested_nxt, 2'd0);
          led_nxt      = lsps_pkg::seg_lit(requested_nxt, 2'd0);
        end
      end else if (seg_next_cnt >= lsps_pkg::seg_count(latched_r) ||
                   requested_nxt != latched_r) begin
        // Pattern start: a pending pulse goes first.
        seg_nxt = 2'd0;
        if (pend_nxt) begin
          pend_nxt     = 1'b0;
          in_pulse_nxt = 1'b1;
          rem_nxt      = lsps_pkg::PULSE_MS;
          led_nxt      = 1'b1;
        end else begin
          latched_nxt = requested_nxt;
          rem_nxt     = lsps_pkg::seg_ms(requested_nxt, 2'd0);
          led_nxt     = lsps_pkg::seg_lit(requested_nxt, 2'd0);
        end
      end else begin
        seg_nxt = seg_next_cnt[1:0];
        rem_nxt = lsps_pkg::seg_ms(latched_r, seg_next_cnt[1:0]);
        led_nxt = lsps_pkg::seg_lit(latched_r, seg_next_cnt[1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      requested_r <= lsps_pkg::MODE_BOOT;
      latched_r   <= lsps_pkg::MODE_BOOT;
      pend_r      <= 1'b0;
      in_pulse_r  <= 1'b0;
      seg_r       <= 2'd0;
      rem_r       <= 10'd500;
      led_r       <= 1'b1;
    end else if (step) begin
      requested_r <= requested_nxt;
      latched_r   <= latched_nxt;
      pend_r      <= pend_nxt;
      in_pulse_r  <= in_pulse_nxt;
      seg_r       <= seg_nxt;
      rem_r       <= rem_nxt;
      led_r       <= led_nxt;
    end
  end

  assign result.pin_level  = led_nxt ^ active_low;
  assign result.shown_mode = latched_nxt;

endmodule

### src/led_status_pattern_sequencer_core.sv
// Status LED pattern sequencer.
// Input channel (in_valid/in_ready/in_data): one transaction per 1 ms tick,
// set-mode request or pulse request. Every accepted transaction yields
// exactly one result on the output channel (out_valid/out_ready/out_data)
// carrying the pin level and the mode of the pattern now playing.
// The result is registered in the output register, or in the skid register.
// Throughput: one transaction per cycle while in_ready is high; the segment
// counter and pattern table update in a single pass, then the result lands
// in the output stage, which holds two results (output register plus skid
// register), so one more transaction is accepted while a result waits;
// in_ready drops only when both are full.
// Configuration: cfg_valid/cfg_data writes the active-low polarity bit;
// cfg_ready is always high. Write it only while the block is idle.
// Reset (rst_n low, synchronous): boot pattern at its first lit 500 ms
// segment, no pulse pending, polarity active high, output stage empty.
module led_status_pattern_sequencer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lsps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lsps_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  logic                active_low_r;
  logic                out_valid_r;
  logic                skid_valid_r;
  lsps_pkg::out_item_t out_data_r;
  lsps_pkg::out_item_t skid_data_r;
  lsps_pkg::out_item_t result;
  logic                push;
  logic                pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  lsps_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (push),
    .item       (in_data),
    .active_low (active_low_r),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_low_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      active_low_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        // advance skid into the output register
        out_data_r   <= skid_data_r;
        skid_valid_r <= push;
        if (push) begin
          skid_data_r <= result;
        end
      end else begin
        out_valid_r <= push;
        if (push) begin
          out_data_r <= result;
        end
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_valid_r <= 1'b1;
        out_data_r  <= result;
      end else begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= result;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output register is empty");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_skid_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |=> skid_valid_r)
    else $error("stalled result dropped from skid");

endmodule

### tb/led_status_pattern_sequencer_core_tb.sv
`timescale 1ns / 100ps

module led_status_pattern_sequencer_core_tb;

  // op code 3 has no name in the package; the block ignores it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 256;

  typedef struct {
    lsps_pkg::in_item_t  item;
    bit                  fixed;
    lsps_pkg::out_item_t want;
  } led_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  lsps_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lsps_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data = 1'b0;

  lsps_pkg::out_item_t expected_leds[$];
  int                  mismatch_count = 0;
  int                  items_sent = 0;
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  quota = 0;

  // predicted sequencer state
  logic       p_active_low;
  logic [2:0] p_requested;
  logic [2:0] p_latched;
  logic       p_pulse_pending;
  logic       p_in_pulse;
  logic [1:0] p_segment;
  logic [9:0] p_remaining;
  logic       p_led_on;

  led_row_t directed_rows [0:24] = '{
    '{'{lsps_pkg::OP_TICK,  3'd0}, 1'b1, '{1'b1, lsps_pkg::MODE_BOOT}},
    '{'{OP_UNUSED,          3'd7}, 1'b1, '{1'b1, lsps_pkg::MODE_BOOT}},
    '{'{lsps_pkg::OP_MODE,  3'd3}, 1'b1, '{1'b0, lsps_pkg::MODE_BOOT}},
    '{'{lsps_pkg::OP_PULSE, 3'd5}, 1'b0, '0},
    '{'{lsps_pkg::OP_PULSE, 3'd2}, 1'b0, '0},
    '{'{lsps_pkg::OP_MODE,  3'd2}, 1'b0, '0},
    '{'{lsps_pkg::OP_TICK,  3'd7}, 1'b0, '0},
    '{'{lsps_pkg::OP_MODE,  3'd0}, 1'b0, '0},
    '{'{lsps_pkg::OP_TICK,  3'd0}, 1'b0, '0},
    '{'{lsps_pkg::OP_MODE,  3'd0}, 1'b0, '0},
    '{'{lsps_pkg::OP_MODE,  3'd0}, 1'b0, '0},
    '{'{lsps_pkg::OP_MODE,  3'd1}, 1'b0, '0},
    '{'{lsps_pkg::OP_MODE,  3'd4}, 1'b0, '0},
    '{'{lsps_pkg::OP_MODE,  3'd4}, 1'b0, '0},
    '{'{lsps_pkg::OP_MODE,  3'd7}, 1'b0, '0},
    '{'{lsps_pkg::OP_MODE,  3'd7}, 1'b0, '0},
    '{'{lsps_pkg::OP_MODE,  3'd7}, 1'b0, '0},
    '{'{lsps_pkg::OP_MODE,  3'd7}, 1'b0, '0},
    '{'{lsps_pkg::OP_MODE,  3'd7}, 1'b0, '0},
    '{'{lsps_pkg::OP_MODE,  3'd5}, 1'b0, '0},
    '{'{lsps_pkg::OP_MODE,  3'd6}, 1'b0, '0},
    '{'{lsps_pkg::OP_PULSE, 3'd0}, 1'b0, '0},
    '{'{OP_UNUSED,          3'd0}, 1'b0, '0},
    '{'{lsps_pkg::OP_MODE,  3'd3}, 1'b0, '0},
    '{'{lsps_pkg::OP_TICK,  3'd3}, 1'b0, '0}
  };

  led_status_pattern_sequencer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [2:0] table_row(input logic [2:0] mode);
    return (mode > lsps_pkg::MODE_ERROR) ? lsps_pkg::MODE_ERROR : mode;
  endfunction

  function automatic int segments_in(input logic [2:0] row);
    case (row)
      lsps_pkg::MODE_OFF, lsps_pkg::MODE_CONNECTED:  return 1;
      lsps_pkg::MODE_CONNECTING, lsps_pkg::MODE_BOOT: return 2;
      default:                                       return 4;
    endcase
  endfunction

  function automatic logic [9:0] segment_length(input logic [2:0] row, input logic [1:0] idx);
    case (row)
      lsps_pkg::MODE_OFF, lsps_pkg::MODE_CONNECTED:
        return (idx == 2'd0) ? 10'd1000 : 10'd0;
      lsps_pkg::MODE_CONNECTING: return (idx < 2'd2) ? 10'd200 : 10'd0;
      lsps_pkg::MODE_BOOT:       return (idx < 2'd2) ? 10'd500 : 10'd0;
      default:                   return (idx == 2'd3) ? 10'd700 : 10'd150;
    endcase
  endfunction

  function automatic logic segment_lit(input logic [2:0] row, input logic [1:0] idx);
    case (row)
      lsps_pkg::MODE_OFF: return 1'b0;
      lsps_pkg::MODE_CONNECTED, lsps_pkg::MODE_CONNECTING, lsps_pkg::MODE_BOOT:
        return idx == 2'd0;
      default: return (idx == 2'd0) || (idx == 2'd2);
    endcase
  endfunction

  task automatic load_led_segment();
    p_remaining = segment_length(table_row(p_latched), p_segment);
    p_led_on    = segment_lit(table_row(p_latched), p_segment);
  endtask

  task automatic begin_led_pattern();
    p_segment = 2'd0;
    if (p_pulse_pending) begin
      p_pulse_pending = 1'b0;
      p_in_pulse      = 1'b1;
      p_remaining     = lsps_pkg::PULSE_MS;
      p_led_on        = 1'b1;
    end else begin
      p_latched = p_requested;
      load_led_segment();
    end
  endtask

  task automatic close_led_segment();
    if (p_in_pulse) begin
      if (p_segment == 2'd0) begin
        p_segment   = 2'd1;
        p_remaining = lsps_pkg::PULSE_MS;
        p_led_on    = 1'b0;
      end else begin
        p_in_pulse = 1'b0;
        p_segment  = 2'd0;
        p_latched  = p_requested;
        load_led_segment();
      end
    end else if (int'(p_segment) + 1 >= segments_in(table_row(p_latched)) ||
                 p_requested != p_latched) begin
      begin_led_pattern();
    end else begin
      p_segment = p_segment + 2'd1;
      load_led_segment();
    end
  endtask

  task automatic advance_led(input lsps_pkg::in_item_t it, output lsps_pkg::out_item_t res);
    case (it.op)
      lsps_pkg::OP_TICK: begin
        if (p_remaining > 10'd1) p_remaining = p_remaining - 10'd1;
        else close_led_segment();
      end
      lsps_pkg::OP_MODE: begin
        p_requested = it.mode_value;
        close_led_segment();
      end
      lsps_pkg::OP_PULSE: begin
        p_pulse_pending = 1'b1;
        close_led_segment();
      end
      default: ;
    endcase
    res.pin_level  = p_led_on ^ p_active_low;
    res.shown_mode = p_latched;
  endtask

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Present one transaction, wait for acceptance, queue its expected result.
  task automatic drive_item(input lsps_pkg::in_item_t it, input bit fixed,
                            input lsps_pkg::out_item_t want);
    lsps_pkg::out_item_t predicted;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_led(it, predicted);
    expected_leds.push_back(fixed ? want : predicted);
    items_sent++;
  endtask

  // Sometimes a request of some kind, then a run of ticks sized around the segment lengths.
  task automatic random_episode();
    lsps_pkg::in_item_t it;
    int                 pick;
    int                 ticks;
    pick = $urandom_range(99);
    it.mode_value = 3'($urandom_range(7));
    if (pick < 45) begin
      it.op = lsps_pkg::OP_MODE;
      drive_item(it, 1'b0, '0);
    end else if (pick < 70) begin
      it.op = lsps_pkg::OP_PULSE;
      drive_item(it, 1'b0, '0);
    end else if (pick < 78) begin
      it.op = OP_UNUSED;
      drive_item(it, 1'b0, '0);
    end
    pick = $urandom_range(99);
    if (pick < 60) ticks = $urandom_range(12);
    else if (pick < 85) ticks = $urandom_range(160, 40);
    else if (pick < 97) ticks = $urandom_range(260, 150);
    else ticks = $urandom_range(1010, 490);
    repeat (ticks) begin
      // stop the run once the phase has its share
      if (items_sent >= quota) break;
      it.op = lsps_pkg::OP_TICK;
      it.mode_value = 3'($urandom_range(7));
      drive_item(it, 1'b0, '0);
    end
  endtask

  // Hold the sender and let every result drain before touching the register.
  task automatic settle_and_configure(input logic value);
    in_valid <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    p_active_low = value;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : result_check
    lsps_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_leds.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected: pin %0b mode %0d",
                                out_data.pin_level, out_data.shown_mode));
      end else begin
        want = expected_leds.pop_front();
        if (out_data.pin_level !== want.pin_level)
          flag_mismatch($sformatf("pin_level got %0b want %0b",
                                  out_data.pin_level, want.pin_level));
        if (out_data.shown_mode !== want.shown_mode)
          flag_mismatch($sformatf("shown_mode got %0d want %0d",
                                  out_data.shown_mode, want.shown_mode));
      end
    end
  end

  initial begin
    int   phase_send [4];
    int   phase_stall [4];
    logic phase_pol [4];

    phase_send  = '{0, 86, 0, 12};
    phase_stall = '{0, 0, 86, 12};
    phase_pol   = '{1'b1, 1'b0, 1'b1, 1'b0};

    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    p_active_low    = 1'b0;
    p_requested     = lsps_pkg::MODE_BOOT;
    p_latched       = lsps_pkg::MODE_BOOT;
    p_pulse_pending = 1'b0;
    p_in_pulse      = 1'b0;
    p_segment       = 2'd0;
    p_remaining     = 10'd500;
    p_led_on        = 1'b1;

    foreach (directed_rows[i])
      drive_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      settle_and_configure(phase_pol[ph]);
      send_idle_pct = phase_send[ph];
      stall_pct     = phase_stall[ph];
      quota = items_sent + PHASE_ITEMS;
      while (items_sent < quota) begin
        random_episode();
        // in phase 1, hold off until the pipeline is empty after each episode that ends in a window mid-phase
        if (ph == 1 && items_sent >= quota - PHASE_ITEMS / 2 &&
            items_sent < quota - PHASE_ITEMS / 2 + 40) begin
          in_valid <= 1'b0;
          while (expected_leds.size() != 0) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
